/* rtl/core/bqd_pkg.sv */
`timescale 1ns / 1ps

package bqd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int HIST_W     = 48;
  localparam int HIST_FRAC  = 39;
  localparam int ACC_W      = 50;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int PROD_SHIFT = (SAMPLE_W - 1) + (COEF_W - 4) - HIST_FRAC;
  localparam int PROD_LSH   = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;
  localparam int PROD_RSH   = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
  localparam int OUT_SHIFT  = HIST_FRAC - (SAMPLE_W - 1);
  localparam int BIT_CNT_W  = $clog2(SAMPLE_W);
  localparam int CFG_ADDR_W = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE =
    {{(COEF_W-1){1'b0}}, 1'b1} << (COEF_W - 4);

  localparam logic signed [ACC_W-1:0] HALF_LSB =
    {{(ACC_W-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAMP_MAX =
    ({{(ACC_W-1){1'b0}}, 1'b1} << (SAMPLE_W - 1)) - {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] SAMP_MIN = ~SAMP_MAX;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2 = 3'd4;

  typedef enum logic [2:0] {
    TAP_B0,
    TAP_B1,
    TAP_B2,
    TAP_A1,
    TAP_A2
  } bqd_tap_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_CLEAR
  } bqd_state_t;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } bqd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } bqd_out_t;

endpackage

/* rtl/core/bqd_serial_mul.sv */
`timescale 1ns / 1ps

module bqd_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [bqd_pkg::SAMPLE_W-1:0]  operand,
  input  logic signed [bqd_pkg::COEF_W-1:0]    coef,
  output logic                                 done,
  output logic signed [bqd_pkg::PROD_W-1:0]    product
);

  import bqd_pkg::*;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [BIT_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0]        sreg_r, sreg_nxt;
  logic signed [COEF_W-1:0]   coef_r, coef_nxt;
  logic signed [COEF_W:0]     hi_r, hi_nxt;
  logic [SAMPLE_W-1:0]        lo_r, lo_nxt;
  logic signed [COEF_W+1:0]   coef_ext;
  logic signed [COEF_W+1:0]   addend;
  logic signed [COEF_W+1:0]   sum;
  logic                       last;
  logic [COEF_W+SAMPLE_W:0]   full;

  assign last     = (cnt_r == BIT_CNT_W'(SAMPLE_W - 1));
  assign coef_ext = {{2{coef_r[COEF_W-1]}}, coef_r};

  // sign bit of the operand carries negative weight
  always_comb begin
    if (!sreg_r[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -coef_ext;
    end else begin
      addend = coef_ext;
    end
    sum = {hi_r[COEF_W], hi_r} + addend;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sreg_nxt = sreg_r;
    coef_nxt = coef_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sreg_nxt = operand;
      coef_nxt = coef;
      hi_nxt   = '0;
    end else if (busy_r) begin
      // shift one operand bit in, one product bit out
      sreg_nxt = sreg_r >> 1;
      hi_nxt   = sum[COEF_W+1:1];
      lo_nxt   = {sum[0], lo_r[SAMPLE_W-1:1]};
      cnt_nxt  = cnt_r + BIT_CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    sreg_r <= sreg_nxt;
    coef_r <= coef_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  assign full    = {hi_r, lo_r};
  assign done    = done_r;
  assign product = full[PROD_W-1:0];

endmodule

/* rtl/core/biquad_iir_filter_core.sv */
`timescale 1ns / 1ps

// Biquad section, transposed direct form II, with a bit-serial multiplier that
// takes one sample bit per cycle. A filter word runs five products through that
// one unit, and the block takes no new word until all five are done; the result
// word is rounded and loaded after the b0 product once the output is free, while
// the other products and the history update finish behind it. A clear word zeroes
// the history and emits a zero word. Coefficients are to be written through the cfg
// port only while the block is idle; the block itself does not enforce this. Unknown indexes are ignored.
module biquad_iir_filter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bqd_pkg::bqd_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bqd_pkg::bqd_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [bqd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bqd_pkg::COEF_W-1:0]         cfg_wdata
);

  import bqd_pkg::*;

  localparam int EXT_W = PROD_W + PROD_LSH + ACC_W;

  bqd_state_t               state_r, state_nxt;
  bqd_tap_t                 tap_r, tap_nxt;
  bqd_tap_t                 start_tap;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [PROD_W-1:0] product;
  logic signed [SAMPLE_W-1:0] mul_operand;
  logic signed [COEF_W-1:0]   mul_coef;

  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  n2_r, n2_nxt;
  logic signed [HIST_W-1:0] h1_r, h1_nxt;
  logic signed [HIST_W-1:0] h2_r, h2_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bqd_out_t                 out_data_r, out_data_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic                     out_load;
  logic                     hist_clear;

  logic signed [EXT_W-1:0]  prod_ext;
  logic signed [EXT_W-1:0]  prod_sh;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  h1_ext, h2_ext;
  logic signed [ACC_W-1:0]  diff2;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  ysh;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                     y_clip;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // bring the exact product to 39 fraction bits (floor on right shift)
  assign prod_ext = $signed({{(EXT_W-PROD_W){product[PROD_W-1]}}, product}) <<< PROD_LSH;
  assign prod_sh  = prod_ext >>> PROD_RSH;
  assign scaled   = prod_sh[ACC_W-1:0];
  assign h1_ext   = {{(ACC_W-HIST_W){h1_r[HIST_W-1]}}, h1_r};
  assign h2_ext   = {{(ACC_W-HIST_W){h2_r[HIST_W-1]}}, h2_r};
  assign diff2    = n2_r - scaled;

  // round half up, then saturate to the sample range
  assign rnd = acc_r + HALF_LSB;
  assign ysh = rnd >>> OUT_SHIFT;
  always_comb begin
    if (ysh > SAMP_MAX) begin
      y_sat  = SAMP_MAX[SAMPLE_W-1:0];
      y_clip = 1'b1;
    end else if (ysh < SAMP_MIN) begin
      y_sat  = SAMP_MIN[SAMPLE_W-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = ysh[SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = in_data.action ? ST_CLEAR : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (tap_r == TAP_B0) begin
            state_nxt = ST_ROUND;
          end else if (tap_r == TAP_A2) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          state_nxt = ST_MUL;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = 1'b0;
    start_tap  = TAP_B0;
    out_load   = 1'b0;
    hist_clear = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mul_start = in_fire & ~in_data.action;
      end
      ST_MUL: begin
        if (mul_done) begin
          case (tap_r)
            TAP_B1: begin
              mul_start = 1'b1;
              start_tap = TAP_B2;
            end
            TAP_B2: begin
              mul_start = 1'b1;
              start_tap = TAP_A1;
            end
            TAP_A1: begin
              mul_start = 1'b1;
              start_tap = TAP_A2;
            end
            default: ;
          endcase
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          out_load  = 1'b1;
          mul_start = 1'b1;
          start_tap = TAP_B1;
        end
      end
      ST_CLEAR: begin
        out_load   = out_free;
        hist_clear = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state_r == ST_IDLE) begin
      mul_operand = in_data.sample_in;
    end else if (start_tap == TAP_A1 || start_tap == TAP_A2) begin
      mul_operand = y_r;
    end else begin
      mul_operand = x_r;
    end
    case (start_tap)
      TAP_B0:  mul_coef = b0_r;
      TAP_B1:  mul_coef = b1_r;
      TAP_B2:  mul_coef = b2_r;
      TAP_A1:  mul_coef = a1_r;
      TAP_A2:  mul_coef = a2_r;
      default: mul_coef = b0_r;
    endcase
  end

  always_comb begin
    tap_nxt       = mul_start ? start_tap : tap_r;
    x_nxt         = in_fire ? in_data.sample_in : x_r;
    y_nxt         = y_r;
    acc_nxt       = acc_r;
    n2_nxt        = n2_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    if (state_r == ST_MUL && mul_done) begin
      case (tap_r)
        TAP_B0:  acc_nxt = scaled + h1_ext;
        TAP_B1:  acc_nxt = scaled + h2_ext;
        TAP_B2:  n2_nxt  = scaled;
        TAP_A1:  acc_nxt = acc_r - scaled;
        TAP_A2: begin
          // commit both history values, wrapping to the history width
          h1_nxt = acc_r[HIST_W-1:0];
          h2_nxt = diff2[HIST_W-1:0];
        end
        default: ;
      endcase
    end

    if (out_load) begin
      if (state_r == ST_ROUND) begin
        y_nxt                   = y_sat;
        out_data_nxt.sample_out = y_sat;
        out_data_nxt.clipped    = y_clip;
      end else begin
        out_data_nxt.sample_out = '0;
        out_data_nxt.clipped    = 1'b0;
      end
    end

    if (hist_clear) begin
      h1_nxt = '0;
      h2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      h1_r        <= '0;
      h2_r        <= '0;
      b0_r        <= COEF_ONE;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_COEF_B0: b0_r <= cfg_wdata;
          REG_COEF_B1: b1_r <= cfg_wdata;
          REG_COEF_B2: b2_r <= cfg_wdata;
          REG_COEF_A1: a1_r <= cfg_wdata;
          REG_COEF_A2: a2_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    tap_r      <= tap_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    acc_r      <= acc_nxt;
    n2_r       <= n2_nxt;
    out_data_r <= out_data_nxt;
  end

  bqd_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_operand),
    .coef    (mul_coef),
    .done    (mul_done),
    .product (product)
  );

endmodule
